/* hw/rtl/ilid_pkg.sv */
// shared types and constants for the indexed list block
// no dependencies; used by ilid_ctrl, ilid_dp and the top level
package ilid_pkg;

  // request opcodes
  localparam logic [2:0] OP_GET      = 3'd0;
  localparam logic [2:0] OP_ADD_HEAD = 3'd1;
  localparam logic [2:0] OP_ADD_TAIL = 3'd2;
  localparam logic [2:0] OP_ADD_IDX  = 3'd3;
  localparam logic [2:0] OP_DEL      = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // source of the result value
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_NEG1,
    RES_MEM
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       setup;
    logic       shift;
    logic       wr_val;
    logic       rd_get;
    logic       inc;
    logic       dec;
    logic       res_we;
    res_sel_e   res_sel;
    logic [1:0] res_st;
    logic       push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       get_ok;
    logic       full;
    logic       ins_range;
    logic       ins_moves;
    logic       del_moves;
    logic       last_step;
    logic       out_free;
  } sts_t;

endpackage

/* hw/rtl/ilid_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ilid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/ilid_ctrl.sv */
// sequencing state machine for the indexed list block
// depends on ilid_pkg for command and status structs and codes
module ilid_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ilid_pkg::sts_t sts_i,
  output ilid_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_WRFIN  = 3'd4;
  localparam logic [2:0] S_GETW   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = ilid_pkg::RES_ZERO;
    cmd_o.res_st  = ilid_pkg::ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.setup = 1'b1;
        unique case (sts_i.opcode) inside
          ilid_pkg::OP_GET: begin
            if (sts_i.get_ok) begin
              cmd_o.rd_get = 1'b1;
              state_d      = S_GETW;
            end else begin
              cmd_o.res_we  = 1'b1;
              cmd_o.res_sel = ilid_pkg::RES_NEG1;
              cmd_o.res_st  = ilid_pkg::ST_RANGE;
              state_d       = S_RESP;
            end
          end
          ilid_pkg::OP_ADD_HEAD, ilid_pkg::OP_ADD_TAIL, ilid_pkg::OP_ADD_IDX: begin
            if (sts_i.ins_range) begin
              cmd_o.res_we = 1'b1;
              cmd_o.res_st = ilid_pkg::ST_RANGE;
              state_d      = S_RESP;
            end else if (sts_i.full) begin
              cmd_o.res_we = 1'b1;
              cmd_o.res_st = ilid_pkg::ST_FULL;
              state_d      = S_RESP;
            end else if (sts_i.ins_moves) begin
              state_d = S_SHIFT;
            end else begin
              state_d = S_WRFIN;
            end
          end
          ilid_pkg::OP_DEL: begin
            if (!sts_i.get_ok) begin
              cmd_o.res_we = 1'b1;
              cmd_o.res_st = ilid_pkg::ST_RANGE;
              state_d      = S_RESP;
            end else if (sts_i.del_moves) begin
              state_d = S_SHIFT;
            end else begin
              cmd_o.dec    = 1'b1;
              cmd_o.res_we = 1'b1;
              state_d      = S_RESP;
            end
          end
          default: begin
            cmd_o.res_we = 1'b1;
            cmd_o.res_st = ilid_pkg::ST_RANGE;
            state_d      = S_RESP;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.last_step) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last moved element is written this cycle
        if (sts_i.opcode == ilid_pkg::OP_DEL) begin
          cmd_o.dec    = 1'b1;
          cmd_o.res_we = 1'b1;
          state_d      = S_RESP;
        end else begin
          state_d = S_WRFIN;
        end
      end
      S_WRFIN: begin
        cmd_o.wr_val = 1'b1;
        cmd_o.inc    = 1'b1;
        cmd_o.res_we = 1'b1;
        state_d      = S_RESP;
      end
      S_GETW: begin
        cmd_o.res_we  = 1'b1;
        cmd_o.res_sel = ilid_pkg::RES_MEM;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ilid_dp.sv */
// datapath of the indexed list block: request registers, element count,
// shift pointer, element ram and output register; uses ilid_pkg and ilid_ram
module ilid_dp #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ilid_pkg::cmd_t     cmd_i,
  output ilid_pkg::sts_t     sts_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] list_index_i,
  input  logic signed [31:0] item_value_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         op_status_o,
  output logic [6:0]         list_length_o
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [2:0]         op_q;
  logic signed [31:0] idx_q;
  logic [31:0]        val_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [AW-1:0]      last_q, last_d;
  logic               down_q, down_d;
  logic               wr_pend_q;
  logic [AW-1:0]      wr_addr_q;
  logic [31:0]        res_val_q;
  logic [1:0]         res_st_q;
  logic               out_valid_q;
  logic [31:0]        out_val_q;
  logic [1:0]         out_st_q;
  logic [6:0]         out_len_q;

  logic [31:0]        rd_data;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;

  logic [31:0]        cnt32;
  logic               idx_neg, idx_lt, idx_le;
  logic [CNT_W-1:0]   ins_pos;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W:0]     p_plus1;
  logic [CNT_W+6:0]   len_ext;

  // ---------------- request decode ----------------
  assign cnt32   = {{(32 - CNT_W){1'b0}}, count_q};
  assign idx_neg = idx_q[31];
  assign idx_lt  = idx_q <  $signed(cnt32);
  assign idx_le  = idx_q <= $signed(cnt32);
  assign cnt_m1  = count_q - {{(CNT_W - 1){1'b0}}, 1'b1};
  assign p_plus1 = {1'b0, idx_q[CNT_W-1:0]} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    case (op_q)
      ilid_pkg::OP_ADD_HEAD: ins_pos = '0;
      ilid_pkg::OP_ADD_TAIL: ins_pos = count_q;
      default:               ins_pos = idx_neg ? '0 : idx_q[CNT_W-1:0];
    endcase
  end

  always_comb begin
    sts_o.opcode    = op_q;
    sts_o.get_ok    = !idx_neg && idx_lt;
    sts_o.full      = (count_q == CNT_W'(CAPACITY));
    sts_o.ins_range = (op_q == ilid_pkg::OP_ADD_IDX) && !idx_le;
    sts_o.ins_moves = count_q > ins_pos;
    sts_o.del_moves = p_plus1 < {1'b0, count_q};
    sts_o.last_step = (ptr_q == last_q);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // ---------------- shift pointer and count ----------------
  always_comb begin
    ptr_d   = ptr_q;
    last_d  = last_q;
    down_d  = down_q;
    count_d = count_q;
    if (cmd_i.setup) begin
      if (op_q == ilid_pkg::OP_DEL) begin
        ptr_d  = p_plus1[AW-1:0];
        last_d = cnt_m1[AW-1:0];
        down_d = 1'b0;
      end else begin
        ptr_d  = cnt_m1[AW-1:0];
        last_d = ins_pos[AW-1:0];
        down_d = 1'b1;
      end
    end else if (cmd_i.shift) begin
      ptr_d = down_q ? (ptr_q - {{(AW - 1){1'b0}}, 1'b1})
                     : (ptr_q + {{(AW - 1){1'b0}}, 1'b1});
    end
    if (cmd_i.inc) begin
      count_d = count_q + {{(CNT_W - 1){1'b0}}, 1'b1};
    end else if (cmd_i.dec) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      wr_pend_q <= cmd_i.shift;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign len_ext = {7'd0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      idx_q <= list_index_i;
      val_q <= item_value_i;
    end
    ptr_q  <= ptr_d;
    last_q <= last_d;
    down_q <= down_d;
    if (cmd_i.shift) begin
      wr_addr_q <= down_q ? (ptr_q + {{(AW - 1){1'b0}}, 1'b1})
                          : (ptr_q - {{(AW - 1){1'b0}}, 1'b1});
    end
    if (cmd_i.res_we) begin
      case (cmd_i.res_sel)
        ilid_pkg::RES_NEG1: res_val_q <= '1;
        ilid_pkg::RES_MEM:  res_val_q <= rd_data;
        default:            res_val_q <= '0;
      endcase
      res_st_q <= cmd_i.res_st;
    end
    if (cmd_i.push) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
      out_len_q <= len_ext[6:0];
    end
  end

  // ---------------- element store ----------------
  assign ram_raddr = cmd_i.rd_get ? idx_q[AW-1:0] : ptr_q;
  assign ram_we    = wr_pend_q || cmd_i.wr_val;
  assign ram_waddr = wr_pend_q ? wr_addr_q : ins_pos[AW-1:0];
  assign ram_wdata = wr_pend_q ? rd_data : val_q;

  ilid_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = $signed(out_val_q);
  assign op_status_o   = out_st_q;
  assign list_length_o = out_len_q;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_pend_q && cmd_i.wr_val))
    else $error("shift write and value write collide");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.inc |-> !sts_o.full)
    else $error("insert completed on a full list");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> out_valid_q)
    else $error("pushed result not presented");

endmodule

/* hw/rtl/indexed_list_insert_delete.sv */
// top level of the indexed list block: ordered list of signed 32-bit values
// depends on ilid_pkg, ilid_ctrl, ilid_dp and ilid_ram
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o | opcode_i, list_index_i, item_value_i
//  out     | output    | out_valid_o / out_stall_i | read_value_o, op_status_o, list_length_o
//
// one request is in work at a time; a finished result sits in the output
// register so the next request can be accepted while it waits.
// an insert or delete makes up to CAPACITY - 1 moves through the single read and
// write port of the element ram, one move a cycle.
// reset clears the element count and the valid flags; ram contents are left.
// a stalled output holds its result and a new one waits in the response state.
module indexed_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] list_index_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         op_status_o,
  output logic [6:0]         list_length_o
);

  // command and status between sequencer and datapath
  ilid_pkg::cmd_t cmd;
  ilid_pkg::sts_t sts;

  // sequencer: decode, shift loop, final write, response
  ilid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: request registers, count, pointer, element ram, output register
  ilid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .list_index_i  (list_index_i),
    .item_value_i  (item_value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .read_value_o  (read_value_o),
    .op_status_o   (op_status_o),
    .list_length_o (list_length_o)
  );

endmodule

/* verif/testbench.sv */
// self-checking testbench for the indexed list block: directed table, then random requests
// depends on ilid_pkg and indexed_list_insert_delete; predicts each untyped result with a local list
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = 64;
  localparam int RAND_ITEMS = 800;
  // cycles with no transaction on either channel before the run is called hung
  localparam int IDLE_LIMIT = 4000;
  // drain time after the last result: longest insert or delete plus margin
  localparam int TAIL_WAIT  = CAP + 20;

  // one result transaction
  typedef struct {
    logic signed [31:0] rd_val;
    logic [1:0]         status;
    logic [6:0]         length;
  } list_result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] idx;
    logic signed [31:0] val;
    bit                 typed;
    list_result_t       res;
  } dir_req_t;

  // stimulus shaping: fill up to full, drain to empty, mixed traffic, raw noise
  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED,
    MODE_NOISE
  } traffic_mode_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [2:0]         opcode_i      = ilid_pkg::OP_GET;
  logic signed [31:0] list_index_i  = '0;
  logic signed [31:0] item_value_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic signed [31:0] read_value_o;
  logic [1:0]         op_status_o;
  logic [6:0]         list_length_o;

  // shadow copy of the list and its length
  logic signed [31:0] shadow_list [CAP];
  int                 shadow_len = 0;

  list_result_t       pending_results [$];
  int                 errors     = 0;
  int                 idle_count = 0;
  int                 hold_cnt   = 0;
  // when set both sides run back to back with no idling
  bit                 no_idle    = 1'b0;

  indexed_list_insert_delete #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .list_index_i (list_index_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .op_status_o  (op_status_o),
    .list_length_o(list_length_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // insert into the shadow list at a position already checked against the length
  function automatic logic [1:0] shadow_insert(int pos, logic signed [31:0] val);
    if (shadow_len >= CAP) return ilid_pkg::ST_FULL;
    for (int i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos] = val;
    shadow_len++;
    return ilid_pkg::ST_DONE;
  endfunction

  // apply one request to the shadow list and return the result it should give
  function automatic list_result_t list_apply(logic [2:0] op, logic signed [31:0] idx,
                                              logic signed [31:0] val);
    list_result_t r;
    r.rd_val = '0;
    r.status = ilid_pkg::ST_DONE;
    case (op)
      ilid_pkg::OP_GET: begin
        // out of range get answers all ones
        if (idx < 0 || idx >= shadow_len) begin
          r.rd_val = -32'sd1;
          r.status = ilid_pkg::ST_RANGE;
        end else begin
          r.rd_val = shadow_list[idx];
        end
      end
      ilid_pkg::OP_ADD_HEAD: r.status = shadow_insert(0, val);
      ilid_pkg::OP_ADD_TAIL: r.status = shadow_insert(shadow_len, val);
      ilid_pkg::OP_ADD_IDX: begin
        // position is checked before fullness; negative means head
        if (idx > shadow_len) r.status = ilid_pkg::ST_RANGE;
        else r.status = shadow_insert((idx < 0) ? 0 : int'(idx), val);
      end
      ilid_pkg::OP_DEL: begin
        if (idx < 0 || idx >= shadow_len) begin
          r.status = ilid_pkg::ST_RANGE;
        end else begin
          for (int i = int'(idx); i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      // unused opcodes change nothing
      default: r.status = ilid_pkg::ST_RANGE;
    endcase
    r.length = shadow_len[6:0];
    return r;
  endfunction

  // present one request transaction, wait for it to be taken, record the expectation
  task automatic send_req(input logic [2:0] op, input logic signed [31:0] idx,
                          input logic signed [31:0] val, input bit typed,
                          input list_result_t typed_res);
    int           gap;
    list_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // valid stays high straight into the next request when there is no gap
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    list_index_i <= idx;
    item_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    pred = list_apply(op, idx, val);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  function automatic dir_req_t dir_row(logic [2:0] op, logic signed [31:0] idx,
                                       logic signed [31:0] val, bit typed,
                                       logic signed [31:0] rd_val, logic [1:0] status,
                                       logic [6:0] length);
    dir_req_t d;
    d.op  = op;
    d.idx = idx;
    d.val = val;
    d.typed = typed;
    d.res.rd_val = rd_val;
    d.res.status = status;
    d.res.length = length;
    return d;
  endfunction

  // mostly positions from zero up to the current length, some just past it, some anywhere
  function automatic logic signed [31:0] pick_index();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, shadow_len);
    if (sel < 90) return shadow_len + $urandom_range(1, 3);
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_op(traffic_mode_e mode);
    int sel;
    sel = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (sel < 30) return ilid_pkg::OP_ADD_HEAD;
        if (sel < 55) return ilid_pkg::OP_ADD_TAIL;
        if (sel < 85) return ilid_pkg::OP_ADD_IDX;
        if (sel < 95) return ilid_pkg::OP_GET;
        return ilid_pkg::OP_DEL;
      end
      MODE_DRAIN: begin
        if (sel < 80) return ilid_pkg::OP_DEL;
        if (sel < 95) return ilid_pkg::OP_GET;
        return ilid_pkg::OP_ADD_IDX;
      end
      MODE_MIXED: return 3'($urandom_range(0, 4));
      default:    return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // result side: check every accepted result, stall at random, watch for a hang
  always @(posedge clk_i) begin
    list_result_t want;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_count <= 0;
    else idle_count <= idle_count + 1;

    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: value %0d status %0d length %0d",
                 $time, read_value_o, op_status_o, list_length_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.rd_val) begin
          $display("%0t: read_value mismatch: expected %0d actual %0d",
                   $time, want.rd_val, read_value_o);
          errors++;
        end
        if (op_status_o !== want.status) begin
          $display("%0t: op_status mismatch: expected %0d actual %0d",
                   $time, want.status, op_status_o);
          errors++;
        end
        if (list_length_o !== want.length) begin
          $display("%0t: list_length mismatch: expected %0d actual %0d",
                   $time, want.length, list_length_o);
          errors++;
        end
      end
      // new hold-off for the next result
      hold_cnt = no_idle ? 0 : $urandom_range(0, 10);
      out_stall_i <= (hold_cnt != 0);
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= (hold_cnt != 0);
    end

    if (idle_count >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // request side: directed table, then shaped random traffic, then drain
  initial begin
    dir_req_t      dir_rows [$];
    list_result_t  unused_res;
    traffic_mode_e mode;
    int            mode_left;
    int            extra;
    logic [2:0]    op;
    logic signed [31:0] idx;

    unused_res = '{rd_val: '0, status: ilid_pkg::ST_DONE, length: '0};

    // empty list: get, delete and insert past the end all miss
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 0, 0,
                               1, -1, ilid_pkg::ST_RANGE, 0));
    dir_rows.push_back(dir_row(ilid_pkg::OP_DEL, 0, 0,
                               1, 0, ilid_pkg::ST_RANGE, 0));
    dir_rows.push_back(dir_row(ilid_pkg::OP_ADD_IDX, 1, 5,
                               1, 0, ilid_pkg::ST_RANGE, 0));
    // most negative insert position goes to the head
    dir_rows.push_back(dir_row(ilid_pkg::OP_ADD_IDX, 32'h8000_0000, 7,
                               1, 0, ilid_pkg::ST_DONE, 1));
    dir_rows.push_back(dir_row(ilid_pkg::OP_ADD_HEAD, 0, 32'h7fff_ffff,
                               1, 0, ilid_pkg::ST_DONE, 2));
    dir_rows.push_back(dir_row(ilid_pkg::OP_ADD_TAIL, 0, 32'h8000_0000,
                               1, 0, ilid_pkg::ST_DONE, 3));
    // insert exactly at the length appends
    dir_rows.push_back(dir_row(ilid_pkg::OP_ADD_IDX, 3, -1,
                               1, 0, ilid_pkg::ST_DONE, 4));
    dir_rows.push_back(dir_row(ilid_pkg::OP_ADD_IDX, 32'h7fff_ffff, 0,
                               1, 0, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 0, 0,
                               0, 0, ilid_pkg::ST_DONE, 0));
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 3, 0,
                               0, 0, ilid_pkg::ST_DONE, 0));
    // get out of range on both sides and at the index extremes
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 4, 0,
                               1, -1, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, -1, 0,
                               1, -1, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 32'h7fff_ffff, 0,
                               1, -1, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 32'h8000_0000, 0,
                               1, -1, ilid_pkg::ST_RANGE, 4));
    // unused opcodes
    dir_rows.push_back(dir_row(3'd5, -1, -1,
                               1, 0, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(3'd6, 0, 0,
                               1, 0, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(3'd7, 1, 123,
                               1, 0, ilid_pkg::ST_RANGE, 4));
    // delete out of range, then deletes, an insert and gets inside the list
    dir_rows.push_back(dir_row(ilid_pkg::OP_DEL, 4, 0,
                               1, 0, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(ilid_pkg::OP_DEL, 32'h8000_0000, 0,
                               1, 0, ilid_pkg::ST_RANGE, 4));
    dir_rows.push_back(dir_row(ilid_pkg::OP_DEL, 1, 0,
                               0, 0, ilid_pkg::ST_DONE, 0));
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 1, 0,
                               0, 0, ilid_pkg::ST_DONE, 0));
    dir_rows.push_back(dir_row(ilid_pkg::OP_DEL, 2, 0,
                               0, 0, ilid_pkg::ST_DONE, 0));
    dir_rows.push_back(dir_row(ilid_pkg::OP_ADD_IDX, 1, 32'h5a5a_5a5a,
                               0, 0, ilid_pkg::ST_DONE, 0));
    dir_rows.push_back(dir_row(ilid_pkg::OP_GET, 1, 0,
                               0, 0, ilid_pkg::ST_DONE, 0));

    // single reset at the start
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_req(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].typed,
               dir_rows[i].res);

    // fill runs until full then keeps pushing against the full store,
    // drain runs until empty then keeps poking the empty list
    mode      = MODE_FILL;
    mode_left = 0;
    extra     = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case (mode)
        MODE_FILL: begin
          if (shadow_len == CAP) extra++;
          if (extra > 12) begin
            mode = MODE_DRAIN;
            extra = 0;
          end
        end
        MODE_DRAIN: begin
          if (shadow_len == 0) extra++;
          if (extra > 6) begin
            mode = MODE_MIXED;
            extra = 0;
            mode_left = $urandom_range(20, 50);
          end
        end
        MODE_MIXED: begin
          if (--mode_left <= 0) begin
            mode = MODE_NOISE;
            mode_left = $urandom_range(10, 30);
          end
        end
        default: begin
          if (--mode_left <= 0) mode = MODE_FILL;
        end
      endcase
      // occasional stretches with no idling on either side
      if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;

      op  = pick_op(mode);
      idx = (mode == MODE_NOISE) ? $urandom : pick_index();
      send_req(op, idx, $urandom, 0, unused_res);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
